@@ rtl/ctskp_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock time-set keypad package
// Shared types, codes and wrap helpers for the keypad editor.
// ----------------------------------------------------------------------------
package ctskp_pkg;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned LIMIT_W     = 4;
    localparam int unsigned COUNT_W     = 5;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 4'd3;
    localparam logic [5:0]         HOURS_TOP          = 6'd24;
    localparam logic [5:0]         SIXTY_TOP          = 6'd60;

    typedef enum logic [2:0] {
        KEY_IDLE = 3'd0,
        KEY_SET  = 3'd1,
        KEY_INC  = 3'd2,
        KEY_DEC  = 3'd3,
        KEY_OK   = 3'd4
    } key_t;

    typedef enum logic [2:0] {
        MODE_RUN     = 3'd0,
        MODE_TIME_H  = 3'd1,
        MODE_TIME_M  = 3'd2,
        MODE_TIME_S  = 3'd3,
        MODE_ALARM_H = 3'd4,
        MODE_ALARM_M = 3'd5,
        MODE_ALARM_S = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        COMMIT_NONE  = 2'd0,
        COMMIT_TIME  = 2'd1,
        COMMIT_ALARM = 2'd2
    } commit_t;

    // One scan tick as unpacked from the input stream
    typedef struct packed {
        logic       set_n;
        logic       inc_n;
        logic       dec_n;
        logic       confirm_n;
        logic [4:0] clock_hours;
        logic [5:0] clock_minutes;
        logic [5:0] clock_seconds;
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
        logic [5:0] alarm_seconds;
    } tick_t;

    // Editor and debounce state
    typedef struct packed {
        mode_t              mode;
        logic [4:0]         hours_edit;
        logic [5:0]         minutes_edit;
        logic [5:0]         seconds_edit;
        key_t               previous_key;
        logic [COUNT_W-1:0] equal_count;
        logic               awaiting_release;
    } state_t;

    // One result item
    typedef struct packed {
        mode_t      mode_now;
        key_t       key_event;
        logic [4:0] edit_hours;
        logic [5:0] edit_minutes;
        logic [5:0] edit_seconds;
        logic       edit_changed;
        commit_t    commit_kind;
        logic [4:0] commit_hours;
        logic [5:0] commit_minutes;
        logic [5:0] commit_seconds;
    } result_t;

    // Step up, wrapping to zero at the top value
    function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] top);
        logic [6:0] sum;
        sum = {1'b0, v} + 7'd1;
        return (sum >= {1'b0, top}) ? 6'd0 : sum[5:0];
    endfunction

    // Step down, wrapping from zero to one below the top value
    function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] top);
        return (v == 6'd0) ? (top - 6'd1) : (v - 6'd1);
    endfunction

endpackage

@@ rtl/ctskp_step.sv @@
// ----------------------------------------------------------------------------
// Clock time-set keypad step
// Key priority, debounce and mode editor update for one scan tick.
// ----------------------------------------------------------------------------
module ctskp_step (
    input  ctskp_pkg::tick_t                  tick,
    input  ctskp_pkg::state_t                 st,
    input  logic [ctskp_pkg::LIMIT_W-1:0]     debounce_limit,
    output ctskp_pkg::state_t                 st_next,
    output ctskp_pkg::result_t                res
);
    import ctskp_pkg::*;

    key_t               sample;
    key_t               key;
    logic [COUNT_W-1:0] count_inc;
    logic               changed;
    commit_t            kind;
    logic [4:0]         commit_h;
    logic [5:0]         commit_m;
    logic [5:0]         commit_s;
    logic [5:0]         hours_wide;

    // Pick one key by priority
    always_comb
    begin
        if (!tick.set_n)
            sample = KEY_SET;
        else if (!tick.inc_n)
            sample = KEY_INC;
        else if (!tick.dec_n)
            sample = KEY_DEC;
        else if (!tick.confirm_n)
            sample = KEY_OK;
        else
            sample = KEY_IDLE;
    end

    assign count_inc  = st.equal_count + COUNT_W'(1);
    assign hours_wide = {1'b0, st.hours_edit};

    // Debounce, then apply the accepted key to the editor
    always_comb
    begin
        st_next  = st;
        key      = KEY_IDLE;
        changed  = 1'b0;
        kind     = COMMIT_NONE;
        commit_h = '0;
        commit_m = '0;
        commit_s = '0;

        if (st.awaiting_release)
        begin
            if (sample == KEY_IDLE)
                st_next.awaiting_release = 1'b0;
        end
        else if (sample != KEY_IDLE && sample == st.previous_key)
        begin
            if (count_inc > {1'b0, debounce_limit})
            begin
                st_next.equal_count      = '0;
                st_next.awaiting_release = 1'b1;
                key                      = sample;
            end
            else
            begin
                st_next.equal_count = count_inc;
            end
        end
        else
        begin
            st_next.equal_count  = '0;
            st_next.previous_key = sample;
        end

        if (key != KEY_IDLE)
        begin
            unique case (st.mode) inside
                MODE_TIME_H, MODE_ALARM_H:
                begin
                    if (key == KEY_INC)
                    begin
                        st_next.hours_edit = 5'(wrap_up(hours_wide, HOURS_TOP));
                        changed = 1'b1;
                    end
                    else if (key == KEY_DEC)
                    begin
                        st_next.hours_edit = 5'(wrap_down(hours_wide, HOURS_TOP));
                        changed = 1'b1;
                    end
                    else if (key == KEY_OK)
                    begin
                        st_next.mode = (st.mode == MODE_TIME_H) ? MODE_TIME_M : MODE_ALARM_M;
                    end
                end
                MODE_TIME_M, MODE_ALARM_M:
                begin
                    if (key == KEY_INC)
                    begin
                        st_next.minutes_edit = wrap_up(st.minutes_edit, SIXTY_TOP);
                        changed = 1'b1;
                    end
                    else if (key == KEY_DEC)
                    begin
                        st_next.minutes_edit = wrap_down(st.minutes_edit, SIXTY_TOP);
                        changed = 1'b1;
                    end
                    else if (key == KEY_OK)
                    begin
                        st_next.mode = (st.mode == MODE_TIME_M) ? MODE_TIME_S : MODE_ALARM_S;
                    end
                end
                MODE_TIME_S, MODE_ALARM_S:
                begin
                    if (key == KEY_INC)
                    begin
                        st_next.seconds_edit = wrap_up(st.seconds_edit, SIXTY_TOP);
                        changed = 1'b1;
                    end
                    else if (key == KEY_DEC)
                    begin
                        st_next.seconds_edit = wrap_down(st.seconds_edit, SIXTY_TOP);
                        changed = 1'b1;
                    end
                    else if (key == KEY_OK)
                    begin
                        commit_h = st.hours_edit;
                        commit_m = st.minutes_edit;
                        commit_s = st.seconds_edit;
                        if (st.mode == MODE_TIME_S)
                        begin
                            // Commit clock time, move on to the alarm
                            kind                 = COMMIT_TIME;
                            st_next.hours_edit   = tick.alarm_hours;
                            st_next.minutes_edit = tick.alarm_minutes;
                            st_next.seconds_edit = tick.alarm_seconds;
                            st_next.mode         = MODE_ALARM_H;
                        end
                        else
                        begin
                            kind         = COMMIT_ALARM;
                            st_next.mode = MODE_RUN;
                        end
                    end
                end
                default:
                begin
                    // Normal mode: only set has a meaning
                    if (key == KEY_SET)
                    begin
                        st_next.hours_edit   = tick.clock_hours;
                        st_next.minutes_edit = tick.clock_minutes;
                        st_next.seconds_edit = tick.clock_seconds;
                        st_next.mode         = MODE_TIME_H;
                    end
                end
            endcase
        end
    end

    // Build the result from the updated state
    always_comb
    begin
        res.mode_now       = st_next.mode;
        res.key_event      = key;
        res.edit_hours     = st_next.hours_edit;
        res.edit_minutes   = st_next.minutes_edit;
        res.edit_seconds   = st_next.seconds_edit;
        res.edit_changed   = changed;
        res.commit_kind    = kind;
        res.commit_hours   = commit_h;
        res.commit_minutes = commit_m;
        res.commit_seconds = commit_s;
    end

endmodule

@@ rtl/clock_time_set_keypad_fsm_top.sv @@
// ----------------------------------------------------------------------------
// Clock time-set keypad controller, top level
// Path: a request passes the input register, then the result register, before
// its result shows on m_tvalid.
// Throughput: one request per cycle unless m_tready stalls; the editor update
// sits between the input register and the result register in a single pass.
// Reset: rst_n clears control state, editor state to normal mode with zero
// edit values, and debounce_limit to 3. Payload registers are not reset.
// ----------------------------------------------------------------------------
module clock_time_set_keypad_fsm_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: set_n, inc_n, dec_n, confirm_n, clock_hours, clock_minutes,
    //          clock_seconds, alarm_hours, alarm_minutes, alarm_seconds, pad
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ctskp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // m_tdata: mode_now, key_event, edit_hours, edit_minutes, edit_seconds,
    //          edit_changed, commit_hours, commit_minutes, commit_seconds, pad
    // m_tuser: commit_kind
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ctskp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [ctskp_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input  logic                                 cfg_we,
    input  logic [ctskp_pkg::LIMIT_W-1:0]        cfg_wdata
);
    import ctskp_pkg::*;

    logic               in_valid_reg;
    tick_t              in_tick_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    logic [LIMIT_W-1:0] limit_reg;
    state_t             state_reg;
    state_t             state_next;
    result_t            res_next;
    tick_t              tick_in;
    logic               advance;

    // Unpack the request
    always_comb
    begin
        tick_in.set_n         = s_tdata[0];
        tick_in.inc_n         = s_tdata[1];
        tick_in.dec_n         = s_tdata[2];
        tick_in.confirm_n     = s_tdata[3];
        tick_in.clock_hours   = s_tdata[8:4];
        tick_in.clock_minutes = s_tdata[14:9];
        tick_in.clock_seconds = s_tdata[20:15];
        tick_in.alarm_hours   = s_tdata[25:21];
        tick_in.alarm_minutes = s_tdata[31:26];
        tick_in.alarm_seconds = s_tdata[37:32];
    end

    // Move the held request into the result register when there is room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ctskp_step u_step (
        .tick           (in_tick_reg),
        .st             (state_reg),
        .debounce_limit (limit_reg),
        .st_next        (state_next),
        .res            (res_next)
    );

    // Hold the debounce limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= DEBOUNCE_LIMIT_RST;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_tick_reg <= tick_in;
    end

    // Editor state advances once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode             <= MODE_RUN;
            state_reg.hours_edit       <= '0;
            state_reg.minutes_edit     <= '0;
            state_reg.seconds_edit     <= '0;
            state_reg.previous_key     <= KEY_IDLE;
            state_reg.equal_count      <= '0;
            state_reg.awaiting_release <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res_next;
    end

    // Pack the result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_res_reg.commit_seconds,
                       out_res_reg.commit_minutes,
                       out_res_reg.commit_hours,
                       out_res_reg.edit_changed,
                       out_res_reg.edit_seconds,
                       out_res_reg.edit_minutes,
                       out_res_reg.edit_hours,
                       out_res_reg.key_event,
                       out_res_reg.mode_now};
    assign m_tuser  = out_res_reg.commit_kind;

endmodule
